/* design/s1d_pkg.sv */
// Shared types and constants of the Steim1 sample decoder.
`timescale 1ns / 1ps

package s1d_pkg;

    localparam int WORD_W          = 32;
    localparam int COUNT_W         = 16;
    localparam int FRAME_WORDS     = 16;
    localparam int POS_W           = $clog2(FRAME_WORDS);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [POS_W-1:0] POS_CONTROL      = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FIRST_SAMPLE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_REVERSE      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST         = POS_W'(FRAME_WORDS - 1);

    localparam logic MODE_RAW    = 1'b0;
    localparam logic MODE_STEIM1 = 1'b1;

    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_D8   = 2'd1;
    localparam logic [1:0] CODE_D16  = 2'd2;
    localparam logic [1:0] CODE_D32  = 2'd3;

    // What the back end has to do with one word.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RAW,
        OP_FIRST,
        OP_D8,
        OP_D16,
        OP_D32
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  word;
        logic               record_begin;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

/* design/s1d_front.sv */
// Front end: tracks frame position and control word, classifies each word.
`timescale 1ns / 1ps

module s1d_front
    import s1d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mode,
    input  logic               i_accept,
    input  logic [WORD_W-1:0]  i_data_word,
    input  logic               i_record_begin,
    input  logic [COUNT_W-1:0] i_sample_count,
    output t_entry             o_entry
);

    logic [WORD_W-1:0] r_ctrl, n_ctrl;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_first, n_first;

    logic [POS_W-1:0]  pos_cur;
    logic              first_cur;
    logic [4:0]        shamt;
    logic [WORD_W-1:0] shifted;
    logic [1:0]        code;
    t_op               op;

    always_comb begin
        pos_cur   = i_record_begin ? POS_CONTROL : r_pos;
        first_cur = i_record_begin ? 1'b1 : r_first;
        shamt     = 5'd30 - {pos_cur, 1'b0};
        shifted   = r_ctrl >> shamt;
        code      = shifted[1:0];
        n_ctrl    = r_ctrl;
        n_pos     = pos_cur;
        n_first   = first_cur;
        op        = OP_NONE;

        if (i_mode == MODE_RAW) begin
            op = OP_RAW;
        end else begin
            if (pos_cur == POS_CONTROL) begin
                n_ctrl = i_data_word;
            end else if (first_cur && pos_cur == POS_FIRST_SAMPLE) begin
                op = OP_FIRST;
            end else if (first_cur && pos_cur == POS_REVERSE) begin
                op = OP_NONE;
            end else begin
                case (code)
                    CODE_NONE: op = OP_NONE;
                    CODE_D8:   op = OP_D8;
                    CODE_D16:  op = OP_D16;
                    CODE_D32:  op = OP_D32;
                    default:   op = OP_NONE;
                endcase
            end
            if (pos_cur == POS_LAST) begin
                n_pos   = POS_CONTROL;
                n_first = 1'b0;
            end else begin
                n_pos = pos_cur + POS_W'(1);
            end
        end

        o_entry.op           = op;
        o_entry.word         = i_data_word;
        o_entry.record_begin = i_record_begin;
        o_entry.count        = i_sample_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= '0;
            r_pos   <= '0;
            r_first <= 1'b0;
        end else if (i_accept) begin
            r_ctrl  <= n_ctrl;
            r_pos   <= n_pos;
            r_first <= n_first;
        end
    end

endmodule

/* design/s1d_queue.sv */
// Short first-word-fall-through queue between front and back end.
`timescale 1ns / 1ps

module s1d_queue
    import s1d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* design/s1d_back.sv */
// Back end: applies one difference per cycle while its output register is free, and registers the samples.
`timescale 1ns / 1ps

module s1d_back
    import s1d_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  t_entry                   i_q_head,
    output logic                     o_q_pop,
    input  logic                     i_pop,
    output logic                     o_valid,
    output logic signed [WORD_W-1:0] o_sample,
    output logic                     o_last_of_word,
    output logic                     o_record_end
);

    logic [COUNT_W-1:0] r_left, n_left;
    logic [WORD_W-1:0]  r_running, n_running;
    logic               r_skip, n_skip;
    logic [1:0]         r_sub;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_sample;
    logic               r_out_last, r_out_end;

    logic [COUNT_W-1:0] left_cur, left_dec;
    logic               skip_cur;
    logic [1:0]         last_sub;
    logic [7:0]         byte_sel;
    logic [15:0]        half_sel;
    logic [WORD_W-1:0]  diff, value;
    logic               is_diff, produces, emit, out_free, advance, word_done;

    always_comb begin
        left_cur  = (i_q_head.record_begin && r_sub == 2'd0) ? i_q_head.count : r_left;
        skip_cur  = (i_q_head.record_begin && r_sub == 2'd0) ? 1'b1 : r_skip;
        left_dec  = left_cur - COUNT_W'(1);

        case (r_sub)
            2'd0:    byte_sel = i_q_head.word[31:24];
            2'd1:    byte_sel = i_q_head.word[23:16];
            2'd2:    byte_sel = i_q_head.word[15:8];
            default: byte_sel = i_q_head.word[7:0];
        endcase
        half_sel = r_sub[0] ? i_q_head.word[15:0] : i_q_head.word[31:16];

        diff      = i_q_head.word;
        is_diff   = 1'b0;
        produces  = 1'b0;
        last_sub  = 2'd0;
        value     = i_q_head.word;
        n_running = r_running;
        n_skip    = skip_cur;

        case (i_q_head.op)
            OP_NONE: begin
                produces = 1'b0;
            end
            OP_RAW: begin
                produces = 1'b1;
            end
            OP_FIRST: begin
                produces  = 1'b1;
                n_running = i_q_head.word;
            end
            OP_D8: begin
                is_diff  = 1'b1;
                last_sub = 2'd3;
                diff     = {{24{byte_sel[7]}}, byte_sel};
            end
            OP_D16: begin
                is_diff  = 1'b1;
                last_sub = 2'd1;
                diff     = {{16{half_sel[15]}}, half_sel};
            end
            OP_D32: begin
                is_diff = 1'b1;
            end
            default: begin
                produces = 1'b0;
            end
        endcase

        // The first difference of a record points back into the previous
        // record, so it is dropped without touching the running sample.
        if (is_diff) begin
            if (skip_cur) begin
                n_skip = 1'b0;
            end else begin
                n_running = r_running + diff;
                value     = n_running;
                produces  = 1'b1;
            end
        end

        emit      = produces && (left_cur != '0);
        n_left    = emit ? left_dec : left_cur;
        word_done = (r_sub == last_sub);
        out_free  = !r_out_valid || i_pop;
        advance   = !i_q_empty && (!emit || out_free);
        o_q_pop   = advance && word_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_running   <= '0;
            r_skip      <= 1'b0;
            r_sub       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_left    <= n_left;
                r_running <= n_running;
                r_skip    <= n_skip;
                r_sub     <= word_done ? 2'd0 : r_sub + 2'd1;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_sample <= value;
            r_out_last   <= word_done || (left_dec == '0);
            r_out_end    <= (left_dec == '0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_last_of_word = r_out_last;
    assign o_record_end   = r_out_end;

endmodule

/* design/steim1_sample_decoder_unit.sv */
// Top level of the Steim1 / raw 32-bit sample decoder.
// With the queue empty, a sample goes through the queue and the back end's output register.
// A word can be taken every cycle while the queue of QUEUE_DEPTH entries is not full; the
// back end applies one difference per cycle while its output is free, so an 8-bit-difference
// word is worked through as four differences, a 16-bit word as two and any other word as one.
// Reset (synchronous, active low) empties the queue, clears all but the output data; raw mode.
`timescale 1ns / 1ps

module steim1_sample_decoder_unit
    import s1d_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input word channel, queue style.
    input  logic                     push,
    output logic                     full,
    input  logic [WORD_W-1:0]        i_data_word,
    input  logic                     i_record_begin,
    input  logic [COUNT_W-1:0]       i_sample_count,
    // Result channel, queue style.
    output logic                     empty,
    input  logic                     pop,
    output logic signed [WORD_W-1:0] o_sample,
    output logic                     o_last_of_word,
    output logic                     o_record_end,
    // Configuration write channel for the encoding mode.
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_data
);

    // The encoding mode must only be changed while the decoder is idle; the block does not
    // enforce this, and the front end samples it directly for every incoming word.
    logic   r_encoding_mode;
    logic   word_accept;
    logic   q_full, q_empty, q_pop, out_valid;
    t_entry front_entry, q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding_mode <= MODE_RAW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_encoding_mode <= i_cfg_data;
        end
    end

    // A word transaction completes whenever the queue has room; the front
    // end classifies the word in the same cycle and writes it into the queue.
    assign full        = q_full;
    assign word_accept = push && !q_full;

    s1d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (r_encoding_mode),
        .i_accept       (word_accept),
        .i_data_word    (i_data_word),
        .i_record_begin (i_record_begin),
        .i_sample_count (i_sample_count),
        .o_entry        (front_entry)
    );

    s1d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (word_accept),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end owns the sample count, the running sample and the
    // skip flag, and keeps one finished sample in its output register.
    s1d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (pop && out_valid),
        .o_valid        (out_valid),
        .o_sample       (o_sample),
        .o_last_of_word (o_last_of_word),
        .o_record_end   (o_record_end)
    );

    assign empty = !out_valid;

endmodule
